FILE: design/top_k_best_list_assert.svh
// ----------------------------------------------------------------------------
// top_k_best_list assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TOP_K_BEST_LIST_ASSERT_SVH
`define TOP_K_BEST_LIST_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define TKBL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define TKBL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tkbl_pkg.sv
// ----------------------------------------------------------------------------
// tkbl_pkg
// Shared constants, types and field layout for the top-k best list
// ----------------------------------------------------------------------------
package tkbl_pkg;

  // list geometry
  localparam int DEPTH      = 8;
  localparam int SLOT_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CFG_W      = 4;

  // field widths
  localparam int FUNC_W     = 2;
  localparam int NODE_W     = 16;
  localparam int COST_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int OUT_SLOT_W = 3;

  // input tdata layout, lowest field first
  localparam int IN_A_LSB     = 0;
  localparam int IN_B_LSB     = IN_A_LSB + NODE_W;
  localparam int IN_C_LSB     = IN_B_LSB + NODE_W;
  localparam int IN_COST_LSB  = IN_C_LSB + NODE_W;
  localparam int IN_BEST_BIT  = IN_COST_LSB + COST_W;
  localparam int IN_FRAC_LSB  = IN_BEST_BIT + 1;
  localparam int IN_FIELDS_W  = IN_FRAC_LSB + FRAC_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // output tdata layout, lowest field first
  localparam int OUT_FIELDS_W = 2 + 3 * NODE_W + COST_W + OUT_SLOT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FUNC_INSERT = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FUNC_CHOOSE = FUNC_W'(2);

  localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(8);
  localparam logic [NODE_W-1:0] NODE_NONE = '1;

  // one list entry
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [NODE_W-1:0] node_c;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] node_a;
  } slot_t;

  localparam slot_t SLOT_EMPTY = '1;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

FILE: design/tkbl_ctrl.sv
// ----------------------------------------------------------------------------
// tkbl_ctrl
// Sequencer: takes an item, runs it on the datapath, owns output valid
// ----------------------------------------------------------------------------
module tkbl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output tkbl_pkg::cmd_t  cmd
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // commands
  always_comb begin
    cmd.load = in_tvalid && (state_r == S_IDLE);
    cmd.exec = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

FILE: design/tkbl_datapath.sv
// ----------------------------------------------------------------------------
// tkbl_datapath
// Slot cells, insert/shift network, choose selector and result register
// ----------------------------------------------------------------------------
module tkbl_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tkbl_pkg::cmd_t                       cmd,
  input  logic                                 cfg_valid,
  input  logic [tkbl_pkg::CFG_W-1:0]           cfg_data,
  input  logic [tkbl_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [tkbl_pkg::FUNC_W-1:0]          in_tuser,
  output logic [tkbl_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int DEPTH  = tkbl_pkg::DEPTH;
  localparam int SLOT_W = tkbl_pkg::SLOT_W;
  localparam int CNT_W  = tkbl_pkg::CNT_W;
  localparam int FRAC_W = tkbl_pkg::FRAC_W;
  localparam int NODE_W = tkbl_pkg::NODE_W;
  localparam int COST_W = tkbl_pkg::COST_W;

  // held item
  logic [tkbl_pkg::FUNC_W-1:0] func_r;
  tkbl_pkg::slot_t             cand_r;
  logic                        best_r;
  logic [FRAC_W-1:0]           frac_r;

  // configuration and slot cells
  logic [tkbl_pkg::CFG_W-1:0]  slots_in_use_r;
  tkbl_pkg::slot_t             slot_r   [DEPTH];
  tkbl_pkg::slot_t             slot_nxt [DEPTH];
  logic [tkbl_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // working signals
  logic [7:0]                  cfg_ext;
  logic [CNT_W-1:0]            n_eff;
  logic                        better;
  tkbl_pkg::slot_t             x_ent;
  logic [DEPTH-1:0]            moved;
  tkbl_pkg::slot_t             ins_slot [DEPTH];
  logic                        any_filled;
  logic [SLOT_W-1:0]           lo;
  logic [CNT_W-1:0]            hi;
  logic [CNT_W-1:0]            span;
  logic [FRAC_W+CNT_W-1:0]     prod;
  logic [CNT_W-1:0]            pick_w;
  logic [SLOT_W-1:0]           pick;
  logic [SLOT_W+2:0]           pick_ext;
  tkbl_pkg::slot_t             pick_ent;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r        <= in_tuser;
      cand_r.node_a <= in_tdata[tkbl_pkg::IN_A_LSB +: NODE_W];
      cand_r.node_b <= in_tdata[tkbl_pkg::IN_B_LSB +: NODE_W];
      cand_r.node_c <= in_tdata[tkbl_pkg::IN_C_LSB +: NODE_W];
      cand_r.cost   <= in_tdata[tkbl_pkg::IN_COST_LSB +: COST_W];
      best_r        <= in_tdata[tkbl_pkg::IN_BEST_BIT];
      frac_r        <= in_tdata[tkbl_pkg::IN_FRAC_LSB +: FRAC_W];
    end
  end

  // slot count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= tkbl_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      slots_in_use_r <= cfg_data;
    end
  end

  // clamp slot count to 1..DEPTH
  always_comb begin
    cfg_ext = 8'(slots_in_use_r);
    if (cfg_ext == 8'd0) begin
      n_eff = CNT_W'(1);
    end else if (cfg_ext > 8'(DEPTH)) begin
      n_eff = CNT_W'(DEPTH);
    end else begin
      n_eff = cfg_ext[CNT_W-1:0];
    end
  end

  // insert: an entry cheaper than the worst one goes in at the worst end and moves past every larger cost
  always_comb begin
    better = slot_r[0].cost > cand_r.cost;
    x_ent  = better ? cand_r : slot_r[0];
    moved[0] = 1'b1;
    for (int k = 1; k < DEPTH; k++) begin
      moved[k] = moved[k-1] && (CNT_W'(k) < n_eff) && (slot_r[k].cost > x_ent.cost);
    end
    for (int k = 0; k < DEPTH - 1; k++) begin
      if (moved[k+1]) begin
        ins_slot[k] = slot_r[k+1];
      end else if (moved[k]) begin
        ins_slot[k] = x_ent;
      end else begin
        ins_slot[k] = slot_r[k];
      end
    end
    ins_slot[DEPTH-1] = moved[DEPTH-1] ? x_ent : slot_r[DEPTH-1];
  end

  // choose: first filled slot, then scaled random offset
  always_comb begin
    any_filled = 1'b0;
    lo         = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if ((CNT_W'(k) < n_eff) && (slot_r[k].node_a != tkbl_pkg::NODE_NONE)) begin
        any_filled = 1'b1;
        lo         = SLOT_W'(k);
      end
    end
    hi       = best_r ? n_eff : n_eff - CNT_W'(1);
    span     = hi - CNT_W'(lo);
    prod     = (FRAC_W+CNT_W)'(frac_r) * (FRAC_W+CNT_W)'(span);
    pick_w   = CNT_W'(lo) + prod[FRAC_W +: CNT_W];
    pick     = pick_w[SLOT_W-1:0];
    pick_ext = (SLOT_W+3)'(pick);
    pick_ent = slot_r[pick];
  end

  // next slot contents and result
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      slot_nxt[k] = slot_r[k];
    end
    out_tdata_nxt = '0;
    case (func_r)
      tkbl_pkg::FUNC_CLEAR: begin
        for (int k = 0; k < DEPTH; k++) begin
          if (CNT_W'(k) < n_eff) slot_nxt[k] = tkbl_pkg::SLOT_EMPTY;
        end
      end
      tkbl_pkg::FUNC_INSERT: begin
        for (int k = 0; k < DEPTH; k++) begin
          slot_nxt[k] = ins_slot[k];
        end
        out_tdata_nxt[0] = better;
      end
      tkbl_pkg::FUNC_CHOOSE: begin
        if (any_filled) begin
          out_tdata_nxt[1]                         = 1'b1;
          out_tdata_nxt[2 +: NODE_W]               = pick_ent.node_a;
          out_tdata_nxt[2 + NODE_W +: NODE_W]      = pick_ent.node_b;
          out_tdata_nxt[2 + 2 * NODE_W +: NODE_W]  = pick_ent.node_c;
          out_tdata_nxt[2 + 3 * NODE_W +: COST_W]  = pick_ent.cost;
          out_tdata_nxt[2 + 3 * NODE_W + COST_W +: tkbl_pkg::OUT_SLOT_W] = pick_ext[2:0];
        end
      end
      default: begin
        out_tdata_nxt = '0;
      end
    endcase
  end

  // slot cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        slot_r[k] <= tkbl_pkg::SLOT_EMPTY;
      end
    end else if (cmd.exec) begin
      for (int k = 0; k < DEPTH; k++) begin
        slot_r[k] <= slot_nxt[k];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

FILE: design/top_k_best_list.sv
// ----------------------------------------------------------------------------
// top_k_best_list
// Keeps the lowest-cost candidates in slots ordered worst to best
// ----------------------------------------------------------------------------
// Input items arrive on in_* (tuser carries the operation: clear, insert or
// choose); every item gives exactly one result item on out_*. The user must
// write the slot count on cfg_* only while the block is idle; the block itself
// does not enforce this. cfg_ready is always high. A taken item is held in the
// item registers until the execute state writes its result register; in_tready
// is high only while the sequencer is idle, and the execute state does the whole
// insert shift or choose selection across all slot cells in parallel.
// Stall: a held result stays on out_tdata while out_tready is low; the next
// item is still taken but waits in the execute state until the result
// register is free.
// Reset: all slots empty (cost all ones, node indices -1), slot count 8,
// no result pending.
// ----------------------------------------------------------------------------
module top_k_best_list (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // node_a, node_b, node_c, new_cost, include_best, random_fraction
  input  logic [tkbl_pkg::IN_TDATA_W-1:0]      in_tdata,
  // func
  input  logic [tkbl_pkg::FUNC_W-1:0]          in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // inserted, found, out_node_a, out_node_b, out_node_c, out_cost, out_slot
  output logic [tkbl_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  // slots_in_use
  input  logic [tkbl_pkg::CFG_W-1:0]           cfg_data
);

  tkbl_pkg::cmd_t cmd;

  // sequencer
  tkbl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // slot cells and result path
  tkbl_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tdata  (out_tdata)
  );

  assign cfg_ready = 1'b1;

endmodule

FILE: design/tkbl_checker.sv
// ----------------------------------------------------------------------------
// tkbl_checker
// Port-level checks on the top-k best list, bound to the top level
// ----------------------------------------------------------------------------
`include "top_k_best_list_assert.svh"

module tkbl_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [tkbl_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  // stalled result holds
  `TKBL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // one item in flight: busy right after taking an item
  `TKBL_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready, "item taken while busy")

  // an operation cannot both insert and choose
  `TKBL_ASSERT_NOW(a_flags_excl, out_tvalid, !(out_tdata[0] && out_tdata[1]), "inserted and found both set")

  // without a found entry the payload is zero
  `TKBL_ASSERT_NOW(a_empty_payload, out_tvalid && !out_tdata[1], (out_tdata >> 2) == '0, "payload set without found")

endmodule

bind top_k_best_list tkbl_checker u_tkbl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
